[hw/rtl/nfbs_pkg.sv]
// shared types and constants for the null-free byte stuffing framer
package nfbs_pkg;

	localparam logic [7:0] ESC_BYTE  = 8'h11;
	localparam logic [7:0] ZERO_CODE = 8'h80;
	localparam logic [7:0] END_CODE  = 8'h01;
	localparam logic [7:0] TRAIL_ONE = 8'h01;
	localparam logic [7:0] TRAIL_TWO = 8'h02;

	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);

	typedef enum logic [1:0] {
		KIND_NONE  = 2'd0,
		KIND_PLAIN = 2'd1,
		KIND_ZERO  = 2'd2,
		KIND_ESC   = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data;
		logic       last;
		logic [1:0] nb;
		logic [2:0] total;
	} cmd_t;

endpackage

[hw/rtl/nfbs_front.sv]
// front part: accepts items, classifies them and pushes commands
module nfbs_front import nfbs_pkg::*; (
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,
	input  logic       s_tuser,
	input  logic       s_tlast,
	input  logic       q_full,
	output logic       q_push,
	output cmd_t       q_cmd
);

	always_comb begin
		q_cmd.data = s_tdata;
		q_cmd.last = s_tlast;
		if (!s_tuser) begin
			q_cmd.kind = KIND_NONE;
			q_cmd.nb   = 2'd0;
		end else if (s_tdata == 8'h00) begin
			q_cmd.kind = KIND_ZERO;
			q_cmd.nb   = 2'd2;
		end else if (s_tdata == ESC_BYTE) begin
			q_cmd.kind = KIND_ESC;
			q_cmd.nb   = 2'd2;
		end else begin
			q_cmd.kind = KIND_PLAIN;
			q_cmd.nb   = 2'd1;
		end
		q_cmd.total = {1'b0, q_cmd.nb} + (s_tlast ? 3'd4 : 3'd0);
	end

	assign s_tready = !q_full;
	// items with neither byte nor end produce nothing
	assign q_push   = s_tvalid && !q_full && (s_tuser || s_tlast);

endmodule

[hw/rtl/nfbs_queue.sv]
// short command queue between front and back parts
module nfbs_queue import nfbs_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output logic empty,
	output cmd_t head
);

	cmd_t               mem_q [QDEPTH];
	logic [QAW-1:0]     wr_ptr_q;
	logic [QAW-1:0]     rd_ptr_q;
	logic [QAW:0]       count_q;
	logic               do_push;
	logic               do_pop;

	assign full    = count_q == (QAW+1)'(QDEPTH);
	assign empty   = count_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[hw/rtl/nfbs_back.sv]
// back part: emits the stuffed bytes and trailer, keeps the running sum
module nfbs_back import nfbs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_empty,
	input  cmd_t       q_head,
	output logic       q_pop,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,
	output logic       m_tuser,
	output logic       m_tlast
);

	logic [2:0] step_q;
	logic [7:0] sum_q;
	logic       out_free;
	logic       fire;
	logic       final_step;
	logic [1:0] tstep;
	logic [7:0] byte_nx;

	assign out_free   = !m_tvalid || m_tready;
	assign fire       = out_free && !q_empty;
	assign final_step = step_q == (q_head.total - 3'd1);
	assign q_pop      = fire && final_step;
	assign tstep      = 2'(step_q - {1'b0, q_head.nb});

	always_comb begin
		byte_nx = q_head.data;
		if (step_q < {1'b0, q_head.nb}) begin
			case (q_head.kind)
				KIND_ZERO: byte_nx = (step_q == 3'd0) ? ESC_BYTE : ZERO_CODE;
				KIND_ESC:  byte_nx = ESC_BYTE;
				default:   byte_nx = q_head.data;
			endcase
		end else begin
			case (tstep)
				2'd0:    byte_nx = ESC_BYTE;
				2'd1:    byte_nx = END_CODE;
				2'd2:    byte_nx = (sum_q == 8'hFF) ? TRAIL_TWO : TRAIL_ONE;
				default: byte_nx = 8'h00 - sum_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			m_tdata <= byte_nx;
			m_tuser <= final_step && q_head.last;
			m_tlast <= final_step;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
			step_q   <= '0;
			sum_q    <= '0;
		end else begin
			if (out_free) begin
				m_tvalid <= !q_empty;
			end
			if (fire) begin
				step_q <= final_step ? 3'd0 : step_q + 3'd1;
				sum_q  <= (final_step && q_head.last) ? 8'h00 : sum_q + byte_nx;
			end
		end
	end

endmodule

[hw/rtl/null_free_byte_stuffing_framer.sv]
// top level of the null-free byte stuffing framer
// usage:
//   input stream s_*: s_tdata carries a payload byte, s_tuser says the byte
//   is valid, s_tlast closes the frame. output stream m_*: one frame byte
//   per item, m_tlast marks the last byte caused by one input item and
//   m_tuser marks the final checksum byte of a frame.
//   a zero byte goes out as 11 80, a byte 11 as 11 11, others unchanged;
//   a closing item adds the end mark 11 01 and a two-byte trailer that
//   makes the 8-bit frame sum zero.
//   throughput: one output byte per cycle unless the receiver stalls, set by the
//   back part, which steps through one command byte by byte; an item therefore yields 0 to
//   6 output bytes (none with neither byte nor close, 2 for an escaped byte, 4 more on close).
//   the front accepts an item per cycle while the 4-entry command queue
//   has room, so input and output stall independently.
//   the first byte of an item is written into the queue and then registered
//   in the output register, with no wait behind other commands when the queue is empty.
//   reset clears the queue, the output valid flag and the running sum.
//   when the receiver stalls, the output holds and the queue fills,
//   after which s_tready drops.
module null_free_byte_stuffing_framer import nfbs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // data_byte
	input  logic       s_tuser,   // has_byte
	input  logic       s_tlast,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // out_byte
	output logic       m_tuser,   // frame_done
	output logic       m_tlast
);

	logic q_full;
	logic q_push;
	logic q_pop;
	logic q_empty;
	cmd_t q_cmd;
	cmd_t q_head;

	nfbs_front u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_cmd    (q_cmd)
	);

	nfbs_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (q_cmd),
		.full     (q_full),
		.pop      (q_pop),
		.empty    (q_empty),
		.head     (q_head)
	);

	nfbs_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.q_head   (q_head),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

[dv/tb_top.sv]
// testbench for the null-free byte stuffing framer: random stalls, stuffing and checksum checks
`timescale 1ns / 100ps

module tb_top;
	import nfbs_pkg::*;

	localparam int WDOG_LIMIT = 5000;

	typedef struct {
		logic [7:0] data_byte;
		logic       has_byte;
		logic       last;
		logic       hold;
	} payload_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       frame_done;
		logic       run_end;
	} frame_byte_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata = 8'h00;   // data_byte
	logic       s_tuser = 1'b0;    // has_byte
	logic       s_tlast = 1'b0;
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;           // out_byte
	logic       m_tuser;           // frame_done
	logic       m_tlast;

	payload_item_t pending_items[$];
	frame_byte_t   frame_bytes_due[$];
	payload_item_t next_item;
	logic [7:0]    frame_sum = 8'h00;
	logic          s_fire = 1'b0;
	int            sent_cnt = 0;
	int            n_items = 1;
	int            idle_cycles = 0;
	int            errors = 0;

	null_free_byte_stuffing_framer dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always #4 clk = ~clk;

	function automatic int traffic_phase();
		int p;
		p = sent_cnt * 3 / n_items;
		return (p > 2) ? 2 : p;
	endfunction

	function automatic int sender_idle_pct();
		case (traffic_phase())
			0: return 13;
			1: return 83;
			default: return 0;
		endcase
	endfunction

	function automatic int receiver_idle_pct();
		case (traffic_phase())
			0: return 83;
			1: return 13;
			default: return 0;
		endcase
	endfunction

	task automatic send_frame_byte(input logic [7:0] b);
		frame_byte_t fb;
		fb.out_byte = b;
		fb.frame_done = 1'b0;
		fb.run_end = 1'b0;
		frame_bytes_due.push_back(fb);
		frame_sum = frame_sum + b;
	endtask

	task automatic stuff_item(input logic [7:0] d, input logic hb, input logic lst);
		int         n0;
		logic [7:0] chk;
		n0 = frame_bytes_due.size();
		if (hb) begin
			if (d == 8'h00) begin
				send_frame_byte(ESC_BYTE);
				send_frame_byte(ZERO_CODE);
			end else if (d == ESC_BYTE) begin
				send_frame_byte(ESC_BYTE);
				send_frame_byte(ESC_BYTE);
			end else begin
				send_frame_byte(d);
			end
		end
		if (lst) begin
			send_frame_byte(ESC_BYTE);
			send_frame_byte(END_CODE);
			chk = 8'h00 - frame_sum;
			if (chk != 8'h01) begin
				send_frame_byte(TRAIL_ONE);
				send_frame_byte(chk - TRAIL_ONE);
			end else begin
				send_frame_byte(TRAIL_TWO);
				send_frame_byte(chk - TRAIL_TWO);
			end
			frame_bytes_due[frame_bytes_due.size() - 1].frame_done = 1'b1;
			frame_sum = 8'h00;
		end
		if (frame_bytes_due.size() > n0)
			frame_bytes_due[frame_bytes_due.size() - 1].run_end = 1'b1;
	endtask

	task automatic add_item(input logic [7:0] d, input logic hb, input logic lst);
		payload_item_t it;
		it.data_byte = d;
		it.has_byte = hb;
		it.last = lst;
		// sender waits for the output to drain before these items
		it.hold = (pending_items.size() == 110 || pending_items.size() == 160);
		pending_items.push_back(it);
	endtask

	// sender
	always @(negedge clk) begin
		if (arst_n && (!s_tvalid || s_fire)) begin
			if (pending_items.size() > 0
					&& !(pending_items[0].hold && frame_bytes_due.size() > 0)
					&& $urandom_range(0, 99) >= sender_idle_pct()) begin
				next_item = pending_items.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= next_item.data_byte;
				s_tuser <= next_item.has_byte;
				s_tlast <= next_item.last;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// receiver
	always @(negedge clk) begin
		if (arst_n)
			m_tready <= ($urandom_range(0, 99) >= receiver_idle_pct());
	end

	// monitor and watchdog
	always @(posedge clk) begin
		frame_byte_t want;
		s_fire <= s_tvalid && s_tready;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (frame_bytes_due.size() == 0) begin
					$display("%0t: unexpected item out=%h done=%b end=%b", $time,
						m_tdata, m_tuser, m_tlast);
					errors++;
				end else begin
					want = frame_bytes_due.pop_front();
					if (m_tdata !== want.out_byte || m_tuser !== want.frame_done
							|| m_tlast !== want.run_end) begin
						$display("%0t: expected out=%h done=%b end=%b, got out=%h done=%b end=%b",
							$time, want.out_byte, want.frame_done, want.run_end,
							m_tdata, m_tuser, m_tlast);
						errors++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				stuff_item(s_tdata, s_tuser, s_tlast);
				sent_cnt++;
			end
			if ((m_tvalid && m_tready) || (s_tvalid && s_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WDOG_LIMIT) begin
				$display("%0t: watchdog expired", $time);
				$display("Mismatches found");
				$finish;
			end
		end
	end

	initial begin
		int         len;
		int         r;
		logic [7:0] gsum;
		logic [7:0] b;
		logic [7:0] tgt;
		logic       lst;

		// directed
		add_item(8'hA5, 1'b0, 1'b0);
		add_item(8'h5A, 1'b0, 1'b1);
		add_item(8'h00, 1'b1, 1'b0);
		add_item(ESC_BYTE, 1'b1, 1'b0);
		add_item(8'hFF, 1'b1, 1'b0);
		add_item(8'h01, 1'b1, 1'b0);
		add_item(8'h80, 1'b1, 1'b1);
		add_item(8'hED, 1'b1, 1'b1);
		add_item(8'hEE, 1'b1, 1'b1);
		add_item(8'hEC, 1'b1, 1'b1);
		add_item(8'h00, 1'b1, 1'b1);
		add_item(ESC_BYTE, 1'b1, 1'b1);
		add_item(8'hFF, 1'b0, 1'b0);
		add_item(8'h7F, 1'b1, 1'b0);
		add_item(8'h00, 1'b0, 1'b1);
		add_item(8'hFE, 1'b1, 1'b0);
		add_item(8'h02, 1'b1, 1'b0);
		add_item(8'h55, 1'b1, 1'b0);
		add_item(8'hAA, 1'b1, 1'b1);

		// random frames
		while (pending_items.size() < 320) begin
			len = $urandom_range(1, 9);
			gsum = 8'h00;
			for (int i = 0; i < len; i++) begin
				lst = (i == len - 1);
				r = $urandom_range(0, 99);
				b = 8'($urandom_range(0, 255));
				if (lst && $urandom_range(0, 5) == 0) begin
					// steer the trailer into its special forms
					tgt = 8'(8'hED + $urandom_range(0, 2));
					b = tgt - gsum;
					if (b == 8'h00 || b == ESC_BYTE)
						add_item(b, 1'b0, 1'b1);
					else
						add_item(b, 1'b1, 1'b1);
				end else if (r < 8) begin
					add_item(b, 1'b0, lst);
				end else begin
					if (r < 25)
						b = 8'h00;
					else if (r < 40)
						b = ESC_BYTE;
					add_item(b, 1'b1, lst);
					if (b == 8'h00)
						gsum = gsum + ESC_BYTE + ZERO_CODE;
					else if (b == ESC_BYTE)
						gsum = gsum + ESC_BYTE + ESC_BYTE;
					else
						gsum = gsum + b;
				end
			end
		end
		n_items = pending_items.size();

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_items.size() > 0 || s_tvalid || frame_bytes_due.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (frame_bytes_due.size() > 0) begin
			$display("%0t: %0d expected items never arrived", $time, frame_bytes_due.size());
			errors++;
		end
		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
